FILE: design/spd_pkg.sv
// Shared types and constants of the slotted page directory.
// No dependencies; every other file of the block imports this package.
package spd_pkg;

  localparam int MAX_SLOTS   = 64;
  localparam int OFFSET_BITS = 16;

  localparam int OFF_W  = OFFSET_BITS;
  localparam int LEN_W  = 16;
  localparam int PAGE_W = 16;
  localparam int ID_W   = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int SUM_W  = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 2;

  localparam logic [PAGE_W-1:0] PAGE_SIZE_RESET = PAGE_W'(4096);

  typedef enum logic [1:0] {
    CMD_APPEND   = 2'd0,
    CMD_RESIZE   = 2'd1,
    CMD_FREE     = 2'd2,
    CMD_REINSERT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ID_W-1:0]  slot_id;
    logic [LEN_W-1:0] length;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  result_id;
    logic [OFF_W-1:0] slot_offset;
    logic [OFF_W-1:0] tail_offset;
    logic [ID_W-1:0]  slot_count;
  } res_t;

  typedef struct packed {
    logic             v;
    logic [OFF_W-1:0] o;
    logic [LEN_W-1:0] l;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic commit;
  } chain_ctl_t;

endpackage

FILE: design/spd_if.sv
// Handshake channels of the slotted page directory: command, result, config.
// Depends on spd_pkg for the payload types.
interface spd_req_if;
  import spd_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spd_res_if;
  import spd_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface spd_cfg_if;
  import spd_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/spd_cell.sv
// One directory cell: a slot's live entry plus its staged update.
// Depends on spd_pkg.
module spd_cell (
  input  logic                clk,
  input  logic                rst,
  input  spd_pkg::chain_ctl_t ctl,
  input  spd_pkg::entry_t     in_cur,
  input  spd_pkg::entry_t     in_pnd,
  output spd_pkg::entry_t     out_cur,
  output spd_pkg::entry_t     out_pnd
);
  import spd_pkg::*;

  logic             cur_v;
  logic [OFF_W-1:0] cur_o;
  logic [LEN_W-1:0] cur_l;
  entry_t           pnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_v <= 1'b0;
    end else if (ctl.shift) begin
      cur_v <= in_cur.v;
    end else if (ctl.commit) begin
      cur_v <= pnd.v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      cur_o <= in_cur.o;
      cur_l <= in_cur.l;
      pnd   <= in_pnd;
    end else if (ctl.commit) begin
      cur_o <= pnd.o;
      cur_l <= pnd.l;
    end
  end

  assign out_cur = '{v: cur_v, o: cur_o, l: cur_l};
  assign out_pnd = pnd;

endmodule

FILE: design/spd_scan.sv
// Command sequencer and the processing element at the head of the cell ring.
// Depends on spd_pkg and the channel interfaces in spd_if.
module spd_scan (
  input  logic                   clk,
  input  logic                   rst,
  spd_req_if.sink                req,
  spd_res_if.source              rsp,
  input  logic [spd_pkg::PAGE_W-1:0] page_size,
  input  spd_pkg::entry_t        head,
  output spd_pkg::entry_t        ring_cur,
  output spd_pkg::entry_t        ring_pnd,
  output spd_pkg::chain_ctl_t    ctl
);
  import spd_pkg::*;

  fsm_e             state;
  fsm_e             state_next;
  logic [IDX_W-1:0] k;
  cmd_e             opc;
  logic [ID_W-1:0]  tgt;
  logic [LEN_W-1:0] len;
  logic             id_bad;
  logic             full;
  logic [SUM_W-1:0] delta;
  logic [OFF_W-1:0] prev_o;
  logic             pred_v;
  logic             tgt_v;
  logic             fit;
  logic [OFF_W-1:0] old_tail;
  logic [OFF_W-1:0] new_tail;
  logic [ID_W-1:0]  new_hi;
  logic [OFF_W-1:0] res_off;
  logic [ID_W-1:0]  highest;
  logic [ID_W-1:0]  count;
  logic             out_valid;
  res_t             out_data;

  logic             accept;
  logic             load;
  logic [ID_W-1:0]  kx;
  logic             eq;
  logic             gt;
  logic             pred_hit;
  logic             is_ins;
  logic             apply;
  logic [SUM_W-1:0] d_res;
  logic [SUM_W-1:0] dsel;
  logic [SUM_W-1:0] sum;
  logic             oob;
  logic [SUM_W-1:0] ins_diff;
  logic             ins_bad;
  entry_t           pnd;
  status_e          st;
  logic             ok;

  // Entry at the head of the ring this cycle.
  assign kx       = ID_W'(k);
  assign eq       = (kx == tgt);
  assign gt       = (kx > tgt);
  assign pred_hit = ((kx + ID_W'(1)) == tgt);
  assign is_ins   = (opc == CMD_APPEND) || (opc == CMD_REINSERT);

  assign d_res    = SUM_W'(head.l) - SUM_W'(len);
  assign ins_diff = SUM_W'(prev_o) - SUM_W'(len);
  assign ins_bad  = SUM_W'(len) > SUM_W'(prev_o);

  always_comb begin
    case (opc)
      CMD_RESIZE:   dsel = eq ? d_res : delta;
      CMD_FREE:     dsel = delta;
      default:      dsel = SUM_W'(0) - SUM_W'(len);
    endcase
  end

  assign apply = head.v && ((opc == CMD_RESIZE) ? (eq || gt) : gt);
  assign sum   = SUM_W'(head.o) + dsel;
  assign oob   = sum[SUM_W-1] || (|sum[SUM_W-2:OFF_W]);

  always_comb begin
    pnd = head;
    if (apply) begin
      pnd.o = sum[OFF_W-1:0];
    end
    if (eq) begin
      case (opc)
        CMD_RESIZE: pnd.l = len;
        CMD_FREE:   pnd.v = 1'b0;
        default: begin
          pnd.v = 1'b1;
          pnd.o = ins_diff[OFF_W-1:0];
          pnd.l = len;
        end
      endcase
    end
  end

  assign ring_cur = head;
  assign ring_pnd = pnd;

  // Outcome, by a precedence of checks that depends on the command.
  always_comb begin
    unique case (opc) inside
      CMD_APPEND:
        st = full ? ST_FULL : (!fit ? ST_RANGE : ST_OK);
      CMD_RESIZE, CMD_FREE:
        st = (id_bad || !tgt_v) ? ST_MISSING : (!fit ? ST_RANGE : ST_OK);
      CMD_REINSERT:
        st = id_bad ? ST_MISSING :
             tgt_v  ? ST_FULL :
             !pred_v ? ST_MISSING :
             !fit   ? ST_RANGE : ST_OK;
      default:
        st = ST_OK;
    endcase
  end
  assign ok = (st == ST_OK);

  always_comb begin
    state_next = state;
    ctl.shift  = 1'b0;
    ctl.commit = 1'b0;
    load       = 1'b0;
    req.ready  = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        ctl.shift = 1'b1;
        if (k == IDX_W'(MAX_SLOTS - 1)) begin
          state_next = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          ctl.commit = ok;
          state_next = FSM_IDLE;
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  assign accept = (state == FSM_IDLE) && req.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan bookkeeping: hold the operands, track predecessor, target and tails.
  always_ff @(posedge clk) begin
    if (accept) begin
      opc      <= cmd_e'(req.data.cmd);
      len      <= req.data.length;
      k        <= '0;
      prev_o   <= OFF_W'(page_size);
      pred_v   <= 1'b1;
      tgt_v    <= 1'b0;
      fit      <= 1'b1;
      old_tail <= OFF_W'(page_size);
      new_tail <= OFF_W'(page_size);
      new_hi   <= '0;
      res_off  <= '0;
      delta    <= '0;
      full     <= (highest == ID_W'(MAX_SLOTS));
      if (cmd_e'(req.data.cmd) == CMD_APPEND) begin
        tgt    <= highest;
        id_bad <= 1'b0;
      end else begin
        tgt    <= req.data.slot_id - ID_W'(1);
        id_bad <= (req.data.slot_id == '0) || (req.data.slot_id > ID_W'(MAX_SLOTS));
      end
    end else if (state == FSM_SCAN) begin
      k <= k + IDX_W'(1);
      if (pred_hit) begin
        prev_o <= head.o;
        pred_v <= head.v;
      end
      if (eq) begin
        tgt_v   <= head.v;
        res_off <= pnd.o;
        if (opc == CMD_FREE) begin
          delta <= SUM_W'(head.l);
        end else if (opc == CMD_RESIZE) begin
          delta <= d_res;
        end
        if (is_ins && ins_bad) begin
          fit <= 1'b0;
        end
      end
      if (apply && oob) begin
        fit <= 1'b0;
      end
      if (head.v) begin
        old_tail <= head.o;
      end
      if (pnd.v) begin
        new_tail <= pnd.o;
        new_hi   <= kx + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest <= '0;
      count   <= '0;
    end else if (load && ok) begin
      highest <= new_hi;
      if (opc == CMD_FREE) begin
        count <= count - ID_W'(1);
      end else if (is_ins) begin
        count <= count + ID_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.status      <= st;
      out_data.result_id   <= ok ? tgt + ID_W'(1) : '0;
      out_data.slot_offset <= (ok && (opc != CMD_FREE)) ? res_off : '0;
      out_data.tail_offset <= ok ? new_tail : old_tail;
      if (!ok) begin
        out_data.slot_count <= count;
      end else if (opc == CMD_FREE) begin
        out_data.slot_count <= count - ID_W'(1);
      end else if (is_ins) begin
        out_data.slot_count <= count + ID_W'(1);
      end else begin
        out_data.slot_count <= count;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

FILE: design/slotted_page_directory_core.sv
// Top level of the slotted page directory: config register, cell ring, sequencer.
// Depends on spd_pkg, spd_if, spd_cell and spd_scan.
//
//  channel  dir  beat carries                          handshake
//  -------  ---  ------------------------------------  -----------------
//  req      in   cmd, slot_id, length                  req.valid/ready
//  rsp      out  status, result_id, slot_offset,       rsp.valid/ready
//                tail_offset, slot_count
//  cfg      in   page_size                             cfg.valid/ready
//
// Each command is accepted, then rotates the directory once through the ring
// of 64 cells past the processing element (one cell per slot), then commits.
// Reset clears the valid marks of all cells at once; no clearing pass.
// The result sits in an output register, so the next command is accepted while
// a result waits; commit of that next command holds until the old beat is taken.
module slotted_page_directory_core (
  input  logic      clk,
  input  logic      rst,
  spd_req_if.sink   req,
  spd_res_if.source rsp,
  spd_cfg_if.sink   cfg
);
  import spd_pkg::*;

  logic [PAGE_W-1:0] page_size;
  chain_ctl_t        ctl;
  entry_t            cur_chain [MAX_SLOTS];
  entry_t            pnd_chain [MAX_SLOTS];
  entry_t            ring_cur;
  entry_t            ring_pnd;

  // Config writes must land only while idle; the block does not enforce it.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size <= PAGE_SIZE_RESET;
    end else if (cfg.valid) begin
      page_size <= cfg.data;
    end
  end

  // Ring: cell i takes from cell i+1; the last cell takes the processed head
  // entry, so cell 0 always presents slot index k during scan step k.
  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    entry_t feed_cur;
    entry_t feed_pnd;

    if (i == MAX_SLOTS - 1) begin : g_last
      assign feed_cur = ring_cur;
      assign feed_pnd = ring_pnd;
    end else begin : g_mid
      assign feed_cur = cur_chain[i+1];
      assign feed_pnd = pnd_chain[i+1];
    end

    spd_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .in_cur (feed_cur),
      .in_pnd (feed_pnd),
      .out_cur(cur_chain[i]),
      .out_pnd(pnd_chain[i])
    );
  end

  spd_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .page_size(page_size),
    .head     (cur_chain[0]),
    .ring_cur (ring_cur),
    .ring_pnd (ring_pnd),
    .ctl      (ctl)
  );

endmodule

FILE: design/spd_checker.sv
// Port-level checks of the slotted page directory, bound to the top level.
// Depends on spd_pkg and slotted_page_directory_core.
module spd_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spd_pkg::res_t rsp_data
);
  import spd_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result beat dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is in flight");

  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != ST_OK) |->
      (rsp_data.result_id == '0) && (rsp_data.slot_offset == '0))
    else $error("error result carries an id or offset");

  a_ok_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status == ST_OK) |->
      (rsp_data.result_id != '0) && (rsp_data.result_id <= ID_W'(MAX_SLOTS)))
    else $error("ok result with id out of range");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.slot_count <= ID_W'(MAX_SLOTS))
    else $error("slot count above table size");

endmodule

bind slotted_page_directory_core spd_checker u_spd_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_data (rsp.data)
);

FILE: tb/slotted_page_directory_core_test.sv
// Self-checking testbench of the slotted page directory core.
// Depends on spd_pkg and spd_if; drives commands, page size writes and result backpressure.
module slotted_page_directory_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spd_pkg::*;

  localparam longint OFF_MAX = (longint'(1) << OFF_W) - 1;

  // Directory predictor plus the queue of results it still owes the block.
  class dir_scoreboard;
    bit                used [1:MAX_SLOTS];
    logic [OFF_W-1:0]  offs [1:MAX_SLOTS];
    logic [LEN_W-1:0]  lens [1:MAX_SLOTS];
    int                top_id;
    int                live;
    int                peak;
    logic [PAGE_W-1:0] page;
    res_t              owed_q[$];
    int unsigned       errors;
    int unsigned       beats;
    int unsigned       cmd_seen [4];
    int unsigned       status_seen [4];

    function new();
      page   = PAGE_SIZE_RESET;
      top_id = 0;
      live   = 0;
      peak   = 0;
      errors = 0;
      beats  = 0;
      foreach (used[k]) used[k] = 1'b0;
      foreach (cmd_seen[k]) cmd_seen[k] = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function logic [OFF_W-1:0] tail();
      return (top_id == 0) ? OFF_W'(page) : offs[top_id];
    endfunction

    // True if moving every live slot from first upward by delta stays in range.
    function bit shift_ok(int first, longint delta);
      longint v;
      for (int k = first; k <= MAX_SLOTS; k++) begin
        if (used[k]) begin
          v = longint'(offs[k]) + delta;
          if (v < 0 || v > OFF_MAX) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void shift(int first, longint delta);
      for (int k = first; k <= MAX_SLOTS; k++)
        if (used[k]) offs[k] = OFF_W'(longint'(offs[k]) + delta);
    endfunction

    // Apply one accepted command and queue the result it must produce.
    function void note_cmd(req_t r);
      res_t             e;
      int               id;
      longint           delta;
      logic [OFF_W-1:0] base;
      e = '0;
      e.status = ST_OK;
      id = int'(r.slot_id);
      case (cmd_e'(r.cmd))
        CMD_APPEND: begin
          base = tail();
          if (top_id >= MAX_SLOTS) begin
            e.status = ST_FULL;
          end else if (r.length > base) begin
            e.status = ST_RANGE;
          end else begin
            id = top_id + 1;
            used[id] = 1'b1;
            offs[id] = base - r.length;
            lens[id] = r.length;
            top_id = id;
            live++;
            e.result_id   = ID_W'(id);
            e.slot_offset = offs[id];
          end
        end
        CMD_RESIZE: begin
          if (id < 1 || id > MAX_SLOTS || !used[id]) begin
            e.status = ST_MISSING;
          end else begin
            delta = longint'(lens[id]) - longint'(r.length);
            if (!shift_ok(id, delta)) begin
              e.status = ST_RANGE;
            end else begin
              shift(id, delta);
              lens[id] = r.length;
              e.result_id   = ID_W'(id);
              e.slot_offset = offs[id];
            end
          end
        end
        CMD_FREE: begin
          if (id < 1 || id > MAX_SLOTS || !used[id]) begin
            e.status = ST_MISSING;
          end else begin
            delta = longint'(lens[id]);
            if (!shift_ok(id + 1, delta)) begin
              e.status = ST_RANGE;
            end else begin
              shift(id + 1, delta);
              used[id] = 1'b0;
              live--;
              top_id = 0;
              for (int k = MAX_SLOTS; k >= 1; k--) begin
                if (used[k]) begin
                  top_id = k;
                  break;
                end
              end
              e.result_id = ID_W'(id);
            end
          end
        end
        default: begin
          if (id < 1 || id > MAX_SLOTS) begin
            e.status = ST_MISSING;
          end else if (used[id]) begin
            e.status = ST_FULL;
          end else if (id != 1 && !used[id-1]) begin
            e.status = ST_MISSING;
          end else begin
            base = (id == 1) ? OFF_W'(page) : offs[id-1];
            if (r.length > base || !shift_ok(id + 1, -longint'(r.length))) begin
              e.status = ST_RANGE;
            end else begin
              shift(id + 1, -longint'(r.length));
              used[id] = 1'b1;
              offs[id] = base - r.length;
              lens[id] = r.length;
              live++;
              if (id > top_id) top_id = id;
              e.result_id   = ID_W'(id);
              e.slot_offset = offs[id];
            end
          end
        end
      endcase
      e.tail_offset = tail();
      e.slot_count  = ID_W'(live);
      if (live > peak) peak = live;
      cmd_seen[r.cmd]++;
      status_seen[e.status]++;
      owed_q.push_back(e);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_beat(res_t got);
      res_t want;
      beats++;
      if (owed_q.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing owed", beats));
        return;
      end
      want = owed_q.pop_front();
      if (got.status !== want.status)
        report($sformatf("beat %0d status %0d, want %0d", beats, got.status, want.status));
      if (got.result_id !== want.result_id)
        report($sformatf("beat %0d result_id %0d, want %0d", beats,
                         got.result_id, want.result_id));
      if (got.slot_offset !== want.slot_offset)
        report($sformatf("beat %0d slot_offset %0d, want %0d", beats,
                         got.slot_offset, want.slot_offset));
      if (got.tail_offset !== want.tail_offset)
        report($sformatf("beat %0d tail_offset %0d, want %0d", beats,
                         got.tail_offset, want.tail_offset));
      if (got.slot_count !== want.slot_count)
        report($sformatf("beat %0d slot_count %0d, want %0d", beats,
                         got.slot_count, want.slot_count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  spd_req_if req_ch();
  spd_res_if rsp_ch();
  spd_cfg_if cfg_ch();

  slotted_page_directory_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  dir_scoreboard     sb;
  bit                tx_quiet;
  bit                rx_quiet;
  int                rx_hold;
  logic [PAGE_W-1:0] odd_page;

  always #10 clk = ~clk;

  // Hard stop: far beyond the slowest legal run, worst gaps included.
  initial begin
    #20_000_000;
    $display("slotted_page_directory_core_test NOT OK");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: drop ready for a random stretch, then take at least one beat.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      rx_hold = idle_len(rx_quiet);
    end
  end

  // Check every result beat against the oldest owed result.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_beat(rsp_ch.data);
  end

  function automatic req_t mk(cmd_e c, int id, int len);
    req_t r;
    r.cmd     = c;
    r.slot_id = ID_W'(id);
    r.length  = LEN_W'(len);
    return r;
  endfunction

  // Present one command, hold it until the block takes the beat, then idle a while.
  task automatic send(req_t r);
    int gap;
    req_ch.data  <= r;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_cmd(r);
    gap = idle_len(tx_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every owed result is in; the block is then idle.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_page(logic [PAGE_W-1:0] v);
    wait_idle();
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.page = v;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Free from the top down so the next page size starts from an empty directory.
  task automatic clear_table();
    while (sb.live > 0) send(mk(CMD_FREE, sb.top_id, 0));
  endtask

  function automatic logic [LEN_W-1:0] pick_len(int max_len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 9) return LEN_W'($urandom);
    if (r < 10) return '1;
    return LEN_W'($urandom_range(1, max_len));
  endfunction

  // Random live id, or any 7-bit id when the directory is empty.
  function automatic int pick_live();
    int ids[$];
    for (int k = 1; k <= MAX_SLOTS; k++) if (sb.used[k]) ids.push_back(k);
    if (ids.size() == 0) return $urandom_range(0, 127);
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Random id that a reinsert can restore: missing, with its predecessor live.
  function automatic int pick_hole();
    int ids[$];
    for (int k = 1; k <= MAX_SLOTS; k++)
      if (!sb.used[k] && (k == 1 || sb.used[k-1])) ids.push_back(k);
    if (ids.size() == 0) return $urandom_range(0, 127);
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Mostly legal commands on the current directory; the rest noise and bad ids.
  function automatic req_t next_cmd(int w_app, int w_rsz, int w_free, int max_len);
    req_t r;
    int   roll;
    int   bad;
    roll = $urandom_range(0, 99);
    bad  = ($urandom_range(0, 99) < 10);
    if (roll < 8) begin
      r.cmd     = 2'($urandom);
      r.slot_id = ID_W'($urandom);
      r.length  = LEN_W'($urandom);
      return r;
    end
    roll = $urandom_range(0, 99);
    if (roll < w_app)
      r = mk(CMD_APPEND, $urandom_range(0, 127), 0);
    else if (roll < w_app + w_rsz)
      r = mk(CMD_RESIZE, bad ? $urandom_range(0, 127) : pick_live(), 0);
    else if (roll < w_app + w_rsz + w_free)
      r = mk(CMD_FREE, bad ? $urandom_range(0, 127) : pick_live(), 0);
    else
      r = mk(CMD_REINSERT, bad ? $urandom_range(0, 127) : pick_hole(), 0);
    r.length = pick_len(max_len);
    return r;
  endfunction

  // One random stretch; hold the sender halfway until the block has drained.
  task automatic run_phase(int n, int w_app, int w_rsz, int w_free, int max_len);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) wait_idle();
      send(next_cmd(w_app, w_rsz, w_free, max_len));
    end
  endtask

  // Errors on an empty directory, then a small hand-built layout at the reset page size.
  task automatic directed();
    send(mk(CMD_FREE, 1, 0));
    send(mk(CMD_RESIZE, 0, 7));
    send(mk(CMD_REINSERT, 0, 5));
    send(mk(CMD_REINSERT, 127, 5));
    send(mk(CMD_REINSERT, 2, 5));
    send(mk(CMD_APPEND, 127, 65535));
    send(mk(CMD_APPEND, 0, 0));
    send(mk(CMD_APPEND, 3, 100));
    send(mk(CMD_APPEND, 0, 4096));
    send(mk(CMD_REINSERT, 1, 1));
    send(mk(CMD_RESIZE, 2, 50));
    send(mk(CMD_RESIZE, 1, 65535));
    send(mk(CMD_RESIZE, 65, 1));
    send(mk(CMD_FREE, 1, 0));
    send(mk(CMD_REINSERT, 1, 20));
    send(mk(CMD_REINSERT, 3, 4027));
    send(mk(CMD_REINSERT, 3, 4026));
    send(mk(CMD_APPEND, 0, 1));
    send(mk(CMD_APPEND, 64, 0));
    send(mk(CMD_FREE, 64, 0));
    send(mk(CMD_FREE, 4, 0));
    send(mk(CMD_RESIZE, 3, 0));
    send(mk(CMD_FREE, 2, 0));
    send(mk(CMD_RESIZE, 127, 16'h5555));
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    rx_hold      = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();

    // Tiny page, tiny records: append runs into the page start quickly.
    clear_table();
    set_page(PAGE_W'(64));
    run_phase(160, 45, 20, 15, 3);

    // Largest page with no idling on either side: fill to a full table.
    clear_table();
    set_page('1);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    run_phase(380, 50, 20, 10, 700);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // Change the page under a populated directory, churn harder.
    odd_page = PAGE_W'($urandom_range(64, 65535));
    set_page(odd_page);
    run_phase(380, 30, 25, 25, 300);

    set_page(PAGE_SIZE_RESET);
    run_phase(300, 25, 25, 30, 200);

    wait_idle();
    repeat (80) @(posedge clk);

    $display("ran %0d commands (append %0d, resize %0d, free %0d, reinsert %0d), %0d beats",
             sb.cmd_seen[CMD_APPEND] + sb.cmd_seen[CMD_RESIZE] + sb.cmd_seen[CMD_FREE]
             + sb.cmd_seen[CMD_REINSERT], sb.cmd_seen[CMD_APPEND], sb.cmd_seen[CMD_RESIZE],
             sb.cmd_seen[CMD_FREE], sb.cmd_seen[CMD_REINSERT], sb.beats);
    $display("status ok %0d missing %0d full/exists %0d range %0d; peak %0d slots; page %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_MISSING], sb.status_seen[ST_FULL],
             sb.status_seen[ST_RANGE], sb.peak, odd_page);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("slotted_page_directory_core_test OK");
    end else begin
      $display("slotted_page_directory_core_test NOT OK");
    end
    $finish;
  end

endmodule
